/* rtl/css_color_string_parser_macros.svh */
// Assertion macros for the CSS color string parser.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef CSS_COLOR_STRING_PARSER_MACROS_SVH
`define CSS_COLOR_STRING_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk, disabled in reset
`define CSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, clocked on clk, disabled in reset
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSS_ASSERT_NOW(label, ante, cons, msg)
`define CSS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/csscp_pkg.sv */
// Package for the CSS color string parser: keyword table and helpers.
// No dependencies.
`default_nettype none
package csscp_pkg;

  localparam int NAME_COUNT   = 148;
  localparam int NAME_CHARS   = 20;
  localparam int MAX_NAME_LEN = 255;
  localparam int MAX_HEX_LEN  = 13;
  localparam int HEX_SLOTS    = 12;

  localparam logic [7:0] CHAR_HASH = 8'h23;

  typedef struct packed {
    logic [8*NAME_CHARS-1:0] txt;
    logic [7:0]              r;
    logic [7:0]              g;
    logic [7:0]              b;
  } name_entry_t;

  // Count the characters of a right-aligned, zero-padded keyword
  function automatic logic [4:0] name_len(input logic [8*NAME_CHARS-1:0] t);
    logic [4:0] n;
    n = 5'd0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (t[8*k +: 8] != 8'h00) n = n + 5'd1;
    end
    return n;
  endfunction

  localparam name_entry_t NAME_TAB [NAME_COUNT] = '{
    '{"aliceblue",8'd240,8'd248,8'd255},'{"antiquewhite",8'd250,8'd235,8'd215},
    '{"aqua",8'd0,8'd255,8'd255},'{"aquamarine",8'd127,8'd255,8'd212},
    '{"azure",8'd240,8'd255,8'd255},'{"beige",8'd245,8'd245,8'd220},
    '{"bisque",8'd255,8'd228,8'd196},'{"black",8'd0,8'd0,8'd0},
    '{"blanchedalmond",8'd255,8'd235,8'd205},'{"blue",8'd0,8'd0,8'd255},
    '{"blueviolet",8'd138,8'd43,8'd226},'{"brown",8'd165,8'd42,8'd42},
    '{"burlywood",8'd222,8'd184,8'd135},'{"cadetblue",8'd95,8'd158,8'd160},
    '{"chartreuse",8'd127,8'd255,8'd0},'{"chocolate",8'd210,8'd105,8'd30},
    '{"coral",8'd255,8'd127,8'd80},'{"cornflowerblue",8'd100,8'd149,8'd237},
    '{"cornsilk",8'd255,8'd248,8'd220},'{"crimson",8'd220,8'd20,8'd60},
    '{"cyan",8'd0,8'd255,8'd255},'{"darkblue",8'd0,8'd0,8'd139},
    '{"darkcyan",8'd0,8'd139,8'd139},'{"darkgoldenrod",8'd184,8'd134,8'd11},
    '{"darkgray",8'd169,8'd169,8'd169},'{"darkgreen",8'd0,8'd100,8'd0},
    '{"darkgrey",8'd169,8'd169,8'd169},'{"darkkhaki",8'd189,8'd183,8'd107},
    '{"darkmagenta",8'd139,8'd0,8'd139},'{"darkolivegreen",8'd85,8'd107,8'd47},
    '{"darkorange",8'd255,8'd140,8'd0},'{"darkorchid",8'd153,8'd50,8'd204},
    '{"darkred",8'd139,8'd0,8'd0},'{"darksalmon",8'd233,8'd150,8'd122},
    '{"darkseagreen",8'd143,8'd188,8'd143},'{"darkslateblue",8'd72,8'd61,8'd139},
    '{"darkslategray",8'd47,8'd79,8'd79},'{"darkslategrey",8'd47,8'd79,8'd79},
    '{"darkturquoise",8'd0,8'd206,8'd209},'{"darkviolet",8'd148,8'd0,8'd211},
    '{"deeppink",8'd255,8'd20,8'd147},'{"deepskyblue",8'd0,8'd191,8'd255},
    '{"dimgray",8'd105,8'd105,8'd105},'{"dimgrey",8'd105,8'd105,8'd105},
    '{"dodgerblue",8'd30,8'd144,8'd255},'{"firebrick",8'd178,8'd34,8'd34},
    '{"floralwhite",8'd255,8'd250,8'd240},'{"forestgreen",8'd34,8'd139,8'd34},
    '{"fuchsia",8'd255,8'd0,8'd255},'{"gainsboro",8'd220,8'd220,8'd220},
    '{"ghostwhite",8'd248,8'd248,8'd255},'{"gold",8'd255,8'd215,8'd0},
    '{"goldenrod",8'd218,8'd165,8'd32},'{"gray",8'd128,8'd128,8'd128},
    '{"green",8'd0,8'd128,8'd0},'{"greenyellow",8'd173,8'd255,8'd47},
    '{"grey",8'd128,8'd128,8'd128},'{"honeydew",8'd240,8'd255,8'd240},
    '{"hotpink",8'd255,8'd105,8'd180},'{"indianred",8'd205,8'd92,8'd92},
    '{"indigo",8'd75,8'd0,8'd130},'{"ivory",8'd255,8'd255,8'd240},
    '{"khaki",8'd240,8'd230,8'd140},'{"lavender",8'd230,8'd230,8'd250},
    '{"lavenderblush",8'd255,8'd240,8'd245},'{"lawngreen",8'd124,8'd252,8'd0},
    '{"lemonchiffon",8'd255,8'd250,8'd205},'{"lightblue",8'd173,8'd216,8'd230},
    '{"lightcoral",8'd240,8'd128,8'd128},'{"lightcyan",8'd224,8'd255,8'd255},
    '{"lightgoldenrodyellow",8'd250,8'd250,8'd210},'{"lightgray",8'd211,8'd211,8'd211},
    '{"lightgreen",8'd144,8'd238,8'd144},'{"lightgrey",8'd211,8'd211,8'd211},
    '{"lightpink",8'd255,8'd182,8'd193},'{"lightsalmon",8'd255,8'd160,8'd122},
    '{"lightseagreen",8'd32,8'd178,8'd170},'{"lightskyblue",8'd135,8'd206,8'd250},
    '{"lightslategray",8'd119,8'd136,8'd153},'{"lightslategrey",8'd119,8'd136,8'd153},
    '{"lightsteelblue",8'd176,8'd196,8'd222},'{"lightyellow",8'd255,8'd255,8'd224},
    '{"lime",8'd0,8'd255,8'd0},'{"limegreen",8'd50,8'd205,8'd50},
    '{"linen",8'd250,8'd240,8'd230},'{"magenta",8'd255,8'd0,8'd255},
    '{"maroon",8'd128,8'd0,8'd0},'{"mediumaquamarine",8'd102,8'd205,8'd170},
    '{"mediumblue",8'd0,8'd0,8'd205},'{"mediumorchid",8'd186,8'd85,8'd211},
    '{"mediumpurple",8'd147,8'd112,8'd219},'{"mediumseagreen",8'd60,8'd179,8'd113},
    '{"mediumslateblue",8'd123,8'd104,8'd238},'{"mediumspringgreen",8'd0,8'd250,8'd154},
    '{"mediumturquoise",8'd72,8'd209,8'd204},'{"mediumvioletred",8'd199,8'd21,8'd133},
    '{"midnightblue",8'd25,8'd25,8'd112},'{"mintcream",8'd245,8'd255,8'd250},
    '{"mistyrose",8'd255,8'd228,8'd225},'{"moccasin",8'd255,8'd228,8'd181},
    '{"navajowhite",8'd255,8'd222,8'd173},'{"navy",8'd0,8'd0,8'd128},
    '{"oldlace",8'd253,8'd245,8'd230},'{"olive",8'd128,8'd128,8'd0},
    '{"olivedrab",8'd107,8'd142,8'd35},'{"orange",8'd255,8'd165,8'd0},
    '{"orangered",8'd255,8'd69,8'd0},'{"orchid",8'd218,8'd112,8'd214},
    '{"palegoldenrod",8'd238,8'd232,8'd170},'{"palegreen",8'd152,8'd251,8'd152},
    '{"paleturquoise",8'd175,8'd238,8'd238},'{"palevioletred",8'd219,8'd112,8'd147},
    '{"papayawhip",8'd255,8'd239,8'd213},'{"peachpuff",8'd255,8'd218,8'd185},
    '{"peru",8'd205,8'd133,8'd63},'{"pink",8'd255,8'd192,8'd203},
    '{"plum",8'd221,8'd160,8'd221},'{"powderblue",8'd176,8'd224,8'd230},
    '{"purple",8'd128,8'd0,8'd128},'{"red",8'd255,8'd0,8'd0},
    '{"rosybrown",8'd188,8'd143,8'd143},'{"royalblue",8'd65,8'd105,8'd225},
    '{"saddlebrown",8'd139,8'd69,8'd19},'{"salmon",8'd250,8'd128,8'd114},
    '{"sandybrown",8'd244,8'd164,8'd96},'{"seagreen",8'd46,8'd139,8'd87},
    '{"seashell",8'd255,8'd245,8'd238},'{"sienna",8'd160,8'd82,8'd45},
    '{"silver",8'd192,8'd192,8'd192},'{"skyblue",8'd135,8'd206,8'd235},
    '{"slateblue",8'd106,8'd90,8'd205},'{"slategray",8'd112,8'd128,8'd144},
    '{"slategrey",8'd112,8'd128,8'd144},'{"snow",8'd255,8'd250,8'd250},
    '{"springgreen",8'd0,8'd255,8'd127},'{"steelblue",8'd70,8'd130,8'd180},
    '{"tan",8'd210,8'd180,8'd140},'{"teal",8'd0,8'd128,8'd128},
    '{"thistle",8'd216,8'd191,8'd216},'{"tomato",8'd255,8'd99,8'd71},
    '{"transparent",8'd0,8'd0,8'd0},'{"turquoise",8'd64,8'd224,8'd208},
    '{"violet",8'd238,8'd130,8'd238},'{"wheat",8'd245,8'd222,8'd179},
    '{"white",8'd255,8'd255,8'd255},'{"whitesmoke",8'd245,8'd245,8'd245},
    '{"yellow",8'd255,8'd255,8'd0},'{"yellowgreen",8'd154,8'd205,8'd50}
  };

endpackage
`default_nettype wire

/* rtl/css_color_string_parser.sv */
// CSS color string parser: hex (#rgb and longer forms) and color keywords.
// Depends on csscp_pkg and css_color_string_parser_macros.svh.
`default_nettype none
`include "css_color_string_parser_macros.svh"

// Takes one byte per cycle; the byte marked last_char yields one result word
// (valid_res, red, green, blue), registered in the input stage and then in the
// result register; the parser is then ready for the next string with no gap.
// Every keyword of the table is compared against the current byte in parallel,
// so each byte costs one cycle; only a stall held on the result port (while the
// last byte of a string waits behind an untaken result) holds back the input.
module css_color_string_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] character,
  input  wire logic       last_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            valid_res,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue
);
  import csscp_pkg::*;

  // Input register
  logic       in_q_valid;
  logic [7:0] char_q;
  logic       last_q;
  logic       advance;

  // Parser state
  logic                  mode_hex,      mode_hex_next;
  logic [8:0]            raw_count,     raw_count_next;
  logic [7:0]            kept_count,    kept_count_next;
  logic [NAME_COUNT-1:0] name_alive,    name_alive_next;
  logic [3:0]            hex_digits     [HEX_SLOTS];
  logic [3:0]            hex_digits_next[HEX_SLOTS];
  logic [HEX_SLOTS-1:0]  hex_bad_digit, hex_bad_digit_next;
  logic                  hex_ended,     hex_ended_next;
  logic [3:0]            hex_len,       hex_len_next;

  logic       accept_in;
  logic [7:0] lc;
  logic       kept;
  logic [8:0] pos;
  logic [4:0] nib;
  logic       res_ok;
  logic [23:0] res_rgb;
  logic       hex_ok, name_ok;
  logic [23:0] hex_rgb, name_rgb;
  logic [NAME_COUNT-1:0] name_hit;
  logic [23:0] name_rgb_each [NAME_COUNT];

  // Nibble value, bit 4 set for a non-hex character
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
    return 5'b10000;
  endfunction

  // Handshake: the input stage drains unless a result cannot be placed
  assign advance   = in_q_valid && (!last_q || !out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept_in) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
    if (accept_in) begin
      char_q <= character;
      last_q <= last_char;
    end
  end

  // Byte classification
  assign kept = !((char_q <= 8'h20) || (char_q >= 8'h7f && char_q <= 8'ha0) ||
                  (char_q == 8'had));
  assign lc   = (char_q >= 8'h41 && char_q <= 8'h5a) ? char_q + 8'd32 : char_q;
  assign pos  = raw_count - 9'd1;
  assign nib  = nibble_of(char_q);

  // Keyword compare against the kept position, one lane per name
  for (genvar g = 0; g < NAME_COUNT; g++) begin : g_name
    localparam logic [4:0] LEN = name_len(NAME_TAB[g].txt);
    logic [4:0] idx;
    logic [7:0] tab_byte;
    always_comb begin
      idx      = LEN - 5'd1 - kept_count[4:0];
      tab_byte = 8'h00;
      if (kept_count < {3'b000, LEN}) tab_byte = NAME_TAB[g].txt[{idx, 3'b000} +: 8];
    end
    assign name_hit[g]      = name_alive_next[g] && (kept_count_next == {3'b000, LEN});
    assign name_rgb_each[g] = name_hit[g] ? {NAME_TAB[g].r, NAME_TAB[g].g, NAME_TAB[g].b}
                                          : 24'h0;
    always_comb begin
      name_alive_next[g] = name_alive[g];
      if (!(raw_count == 9'd0 && char_q == CHAR_HASH) && !mode_hex && kept)
        name_alive_next[g] = name_alive[g] && (tab_byte == lc);
    end
  end

  // State update for one byte
  always_comb begin
    mode_hex_next      = mode_hex;
    kept_count_next    = kept_count;
    hex_digits_next    = hex_digits;
    hex_bad_digit_next = hex_bad_digit;
    hex_ended_next     = hex_ended;
    hex_len_next       = hex_len;
    raw_count_next     = (raw_count == 9'h1ff) ? raw_count : raw_count + 9'd1;
    if (raw_count == 9'd0 && char_q == CHAR_HASH) begin
      mode_hex_next = 1'b1;
    end else if (mode_hex) begin
      if (!hex_ended) begin
        if (char_q == 8'h00) begin
          hex_ended_next = 1'b1;
          hex_len_next   = pos[3:0];
        end else if (pos < 9'(HEX_SLOTS)) begin
          hex_digits_next[pos[3:0]]    = nib[4] ? 4'h0 : nib[3:0];
          hex_bad_digit_next[pos[3:0]] = hex_bad_digit[pos[3:0]] | nib[4];
        end
      end
    end else if (kept) begin
      if (kept_count != 8'hff) kept_count_next = kept_count + 8'd1;
    end
  end

  // Hex result from the updated digits
  always_comb begin
    logic [3:0] n;
    logic [3:0] a1, a2;
    n       = hex_ended_next ? hex_len_next : raw_count_next[3:0] - 4'd1;
    a1      = 4'd0;
    a2      = 4'd0;
    hex_ok  = 1'b0;
    hex_rgb = 24'h0;
    case (n)
      4'd3: begin
        hex_ok  = (hex_bad_digit_next[2:0] == 3'b000);
        hex_rgb = {hex_digits_next[0], hex_digits_next[0], hex_digits_next[1],
                   hex_digits_next[1], hex_digits_next[2], hex_digits_next[2]};
      end
      4'd6, 4'd9, 4'd12: begin
        a1 = (n == 4'd6) ? 4'd2 : (n == 4'd9) ? 4'd3 : 4'd4;
        a2 = {a1[2:0], 1'b0};
        hex_ok  = (hex_bad_digit_next[1:0] == 2'b00) &&
                  (hex_bad_digit_next[a1 +: 2] == 2'b00) &&
                  (hex_bad_digit_next[a2 +: 2] == 2'b00);
        hex_rgb = {hex_digits_next[0], hex_digits_next[1],
                   hex_digits_next[a1], hex_digits_next[a1 + 4'd1],
                   hex_digits_next[a2], hex_digits_next[a2 + 4'd1]};
      end
      default: hex_ok = 1'b0;
    endcase
    if (raw_count_next > 9'(MAX_HEX_LEN)) hex_ok = 1'b0;
  end

  // Keyword result: at most one name can match exactly
  always_comb begin
    name_rgb = 24'h0;
    for (int i = 0; i < NAME_COUNT; i++) name_rgb = name_rgb | name_rgb_each[i];
    name_ok = (|name_hit) && (raw_count_next <= 9'(MAX_NAME_LEN));
  end

  assign res_ok  = mode_hex_next ? hex_ok : name_ok;
  assign res_rgb = res_ok ? (mode_hex_next ? hex_rgb : name_rgb) : 24'h0;

  // Commit state; the last byte returns the parser to its reset state
  always_ff @(posedge clk) begin
    if (rst || (advance && last_q)) begin
      mode_hex      <= 1'b0;
      raw_count     <= 9'd0;
      kept_count    <= 8'd0;
      name_alive    <= '1;
      hex_bad_digit <= '0;
      hex_ended     <= 1'b0;
      hex_len       <= 4'd0;
      for (int i = 0; i < HEX_SLOTS; i++) hex_digits[i] <= 4'h0;
    end else if (advance) begin
      mode_hex      <= mode_hex_next;
      raw_count     <= raw_count_next;
      kept_count    <= kept_count_next;
      name_alive    <= name_alive_next;
      hex_bad_digit <= hex_bad_digit_next;
      hex_ended     <= hex_ended_next;
      hex_len       <= hex_len_next;
      hex_digits    <= hex_digits_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_q) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && last_q) begin
      valid_res <= res_ok;
      red       <= res_rgb[23:16];
      green     <= res_rgb[15:8];
      blue      <= res_rgb[7:0];
    end
  end

  `CSS_ASSERT_NOW(a_invalid_zero, out_valid && !valid_res, red == 8'd0 && green == 8'd0 && blue == 8'd0, "invalid result carries a color")
  `CSS_ASSERT_NEXT(a_reset_after_last, advance && last_q, raw_count == 9'd0 && !mode_hex && !hex_ended, "state not cleared after last byte")
  `CSS_ASSERT_NEXT(a_hold_input_stage, in_q_valid && !advance, in_q_valid && $stable(char_q) && $stable(last_q), "input stage overwritten while held")
  `CSS_ASSERT_NOW(a_no_drop_result, out_valid && out_stall && in_q_valid && last_q, in_stall, "result overwritten while stalled")

endmodule
`default_nettype wire
